// ----- sv/laser_scan_gate_and_decimate_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the laser scan gate and decimate core
// Expect clk and rst_n in scope at the point of use.
// ---------------------------------------------------------------------------
`ifndef LASER_SCAN_GATE_AND_DECIMATE_CORE_ASSERT_SVH
`define LASER_SCAN_GATE_AND_DECIMATE_CORE_ASSERT_SVH

// same-cycle implication
`define LSGD_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");

// next-cycle implication
`define LSGD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/lsgd_pkg.sv -----
// ---------------------------------------------------------------------------
// lsgd_pkg
// Shared constants, types and tables of the laser scan gate and decimate core.
// ---------------------------------------------------------------------------
package lsgd_pkg;

    localparam int MAX_SAMPLES       = 2048;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_LEN          = 24;
    localparam int NITER = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;
    localparam int IT_W  = 5;

    localparam int IDX_W     = 11;
    localparam int IDX_LIMIT = (MAX_SAMPLES - 1 < 2047) ? (MAX_SAMPLES - 1) : 2047;

    localparam int RANGE_W    = 16;
    localparam int ANG_CFG_W  = 19;
    localparam int STEP_W     = 17;
    localparam int DEC_W      = 12;
    localparam int PT_W       = 17;
    localparam int TRIG_W     = 16;
    localparam int ANG_W      = 30;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;
    localparam int CNT_W      = 5;

    localparam int MUL_W = 33;
    localparam int DX_W  = 18;
    localparam int MAG_W = 17;
    localparam int SQ_W  = 36;
    localparam int DD_W  = 24;

    localparam int CA_W  = 36;
    localparam int CXY_W = 34;

    localparam int TRIG_MAX = 32767;
    localparam int TRIG_MIN = -32768;
    localparam int PT_MAX   = 65535;
    localparam int PT_MIN   = -65536;

    localparam logic signed [CA_W-1:0]  PI_Q30      = 36'sd3373259426;
    localparam logic signed [CA_W-1:0]  TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [CA_W-1:0]  HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CXY_W-1:0] K_Q30       = 34'sd652032874;

    localparam int RST_RANGE_MIN  = 51;
    localparam int RST_RANGE_MAX  = 2048;
    localparam int RST_GATE_MIN   = -205887;
    localparam int RST_GATE_MAX   = 205887;
    localparam int RST_ANG_START  = -205887;
    localparam int RST_ANG_STEP   = 286;
    localparam int RST_DEC_DIST   = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_MIN,
        CFG_RANGE_MAX,
        CFG_GATE_MIN,
        CFG_GATE_MAX,
        CFG_ANG_START,
        CFG_ANG_STEP,
        CFG_DEC_DIST
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_GATE,
        ST_CORDIC,
        ST_MULT,
        ST_ROUND,
        ST_DPREP,
        ST_DIST,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } cordic_res_t;

    function automatic logic signed [CA_W-1:0] atan_q30(input logic [IT_W-1:0] i);
        logic signed [CA_W-1:0] v;
        case (i)
            5'd0:    v = 36'sd843314857;
            5'd1:    v = 36'sd497837829;
            5'd2:    v = 36'sd263043837;
            5'd3:    v = 36'sd133525159;
            5'd4:    v = 36'sd67021687;
            5'd5:    v = 36'sd33543516;
            5'd6:    v = 36'sd16775851;
            5'd7:    v = 36'sd8388437;
            5'd8:    v = 36'sd4194283;
            5'd9:    v = 36'sd2097149;
            5'd10:   v = 36'sd1048576;
            5'd11:   v = 36'sd524288;
            5'd12:   v = 36'sd262144;
            5'd13:   v = 36'sd131072;
            5'd14:   v = 36'sd65536;
            5'd15:   v = 36'sd32768;
            5'd16:   v = 36'sd16384;
            5'd17:   v = 36'sd8192;
            5'd18:   v = 36'sd4096;
            5'd19:   v = 36'sd2048;
            5'd20:   v = 36'sd1024;
            5'd21:   v = 36'sd512;
            5'd22:   v = 36'sd256;
            5'd23:   v = 36'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/lsgd_cordic.sv -----
// ---------------------------------------------------------------------------
// lsgd_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q1.15 out.
// ---------------------------------------------------------------------------
module lsgd_cordic (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [lsgd_pkg::ANG_CFG_W-1:0]  angle,
    output lsgd_pkg::cordic_res_t                  res
);
    import lsgd_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    fin_reg, fin_next;
    logic [IT_W-1:0]         it_reg, it_next;
    logic signed [CA_W-1:0]  a_reg, a_next;
    logic signed [CXY_W-1:0] x_reg, x_next;
    logic signed [CXY_W-1:0] y_reg, y_next;
    logic                    neg_reg, neg_next;
    cordic_res_t             res_reg, res_next;

    logic signed [CA_W-1:0]  a0, a1;
    logic signed [CXY_W-1:0] xs, ys, xo, yo, vx, vy;

    always_comb
    begin
        a0 = {{(CA_W-ANG_CFG_W-14){angle[ANG_CFG_W-1]}}, angle, 14'b0};
        if (a0 > PI_Q30)
        begin
            a1 = a0 - TWO_PI_Q30;
        end
        else if (a0 < -PI_Q30)
        begin
            a1 = a0 + TWO_PI_Q30;
        end
        else
        begin
            a1 = a0;
        end
        xs = x_reg >>> it_reg;
        ys = y_reg >>> it_reg;
        xo = neg_reg ? -x_reg : x_reg;
        yo = neg_reg ? -y_reg : y_reg;
        vx = (xo + CXY_W'(16384)) >>> 15;
        vy = (yo + CXY_W'(16384)) >>> 15;

        busy_next = busy_reg;
        fin_next  = 1'b0;
        it_next   = it_reg;
        a_next    = a_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        res_next.done = 1'b0;

        if (start)
        begin
            busy_next = 1'b1;
            it_next   = '0;
            x_next    = K_Q30;
            y_next    = '0;
            if (a1 > HALF_PI_Q30)
            begin
                a_next   = a1 - PI_Q30;
                neg_next = 1'b1;
            end
            else if (a1 < -HALF_PI_Q30)
            begin
                a_next   = a1 + PI_Q30;
                neg_next = 1'b1;
            end
            else
            begin
                a_next   = a1;
                neg_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (!a_reg[CA_W-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                a_next = a_reg - atan_q30(it_reg);
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                a_next = a_reg + atan_q30(it_reg);
            end
            it_next = it_reg + 1'b1;
            if (it_reg == IT_W'(NITER - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end

        if (fin_reg)
        begin
            res_next.done  = 1'b1;
            res_next.cos_v = (vx > TRIG_MAX) ? TRIG_W'(TRIG_MAX) :
                             (vx < TRIG_MIN) ? TRIG_W'(TRIG_MIN) : vx[TRIG_W-1:0];
            res_next.sin_v = (vy > TRIG_MAX) ? TRIG_W'(TRIG_MAX) :
                             (vy < TRIG_MIN) ? TRIG_W'(TRIG_MIN) : vy[TRIG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            res_reg  <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg  <= it_next;
        a_reg   <= a_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        neg_reg <= neg_next;
    end

    assign res = res_reg;

endmodule

// ----- sv/laser_scan_gate_and_decimate_core.sv -----
// ---------------------------------------------------------------------------
// laser_scan_gate_and_decimate_core
// Range/angle gate, polar-to-Cartesian conversion and distance decimation.
// ---------------------------------------------------------------------------
// Input beats carry one range sample and a scan_end flag; the beam index is
// counted inside. Each input beat yields exactly one output beat with keep,
// point_x/point_y (zero when dropped), beam_index and end_of_scan.
// Both data channels use valid/stall; the config channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) is always ready; the user sees that it is
// written only while idle, as the core does not enforce this. One beat at a
// time: the angle is built by a shift-add multiply, the CORDIC takes one
// micro-rotation per cycle, range scaling is a serial multiply and the
// distance squares a serial multiply. A gated-out beat skips the CORDIC,
// scaling and distance states and reaches the output sooner; the next input
// beat is taken once the result has moved into the output register.
// A finished result sits in the output register while the next input beat
// is accepted; a stalled receiver holds the result, and the core waits in
// its done state until the output register frees up.
// Reset restores the register defaults and clears beam index and the
// previous point; no output beat is pending after reset.
// ---------------------------------------------------------------------------
`include "laser_scan_gate_and_decimate_core_assert.svh"

module laser_scan_gate_and_decimate_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [lsgd_pkg::RANGE_W-1:0]            range,
    input  logic                                    scan_end,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    keep,
    output logic signed [lsgd_pkg::PT_W-1:0]        point_x,
    output logic signed [lsgd_pkg::PT_W-1:0]        point_y,
    output logic [lsgd_pkg::IDX_W-1:0]              beam_index,
    output logic                                    end_of_scan,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [lsgd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [lsgd_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import lsgd_pkg::*;

    // config registers
    logic [RANGE_W-1:0]          range_min_reg, range_max_reg;
    logic signed [ANG_CFG_W-1:0] gate_min_reg, gate_max_reg, ang_start_reg;
    logic signed [STEP_W-1:0]    ang_step_reg;
    logic [DEC_W-1:0]            dec_dist_reg;

    // control state
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [IDX_W-1:0]        counter_reg, counter_next;
    logic                    have_prev_reg, have_prev_next;
    logic signed [PT_W-1:0]  prev_x_reg, prev_x_next;
    logic signed [PT_W-1:0]  prev_y_reg, prev_y_next;
    logic                    out_valid_reg, out_valid_next;

    // working payload
    logic [RANGE_W-1:0]      range_reg, range_next;
    logic                    end_reg, end_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        idx_sh_reg, idx_sh_next;
    logic signed [ANG_W-1:0] angle_reg, angle_next;
    logic signed [ANG_W-1:0] step_sh_reg, step_sh_next;
    logic [RANGE_W-1:0]      rsh_reg, rsh_next;
    logic signed [MUL_W-1:0] mcx_reg, mcx_next, mcy_reg, mcy_next;
    logic signed [MUL_W-1:0] accx_reg, accx_next, accy_reg, accy_next;
    logic signed [PT_W-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic [MAG_W-1:0]        dxs_reg, dxs_next, dys_reg, dys_next;
    logic [SQ_W-1:0]         mdx_reg, mdx_next, mdy_reg, mdy_next, sq_reg, sq_next;
    logic [DEC_W-1:0]        dds_reg, dds_next;
    logic [DD_W-1:0]         mdd_reg, mdd_next, dd_reg, dd_next;
    logic                    keep_reg, keep_next;
    logic signed [PT_W-1:0]  px_reg, px_next, py_reg, py_next;

    // output register
    logic                    keep_o_reg, eos_o_reg;
    logic signed [PT_W-1:0]  px_o_reg, py_o_reg;
    logic [IDX_W-1:0]        idx_o_reg;

    logic                    accept, gate_pass, out_load, cordic_start;
    logic signed [MUL_W-1:0] vx, vy;
    logic signed [DX_W-1:0]  dx, dy;
    cordic_res_t             cres;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign gate_pass = (range_reg > range_min_reg) && (range_reg < range_max_reg) &&
                       (angle_reg > gate_min_reg) && (angle_reg < gate_max_reg);
    assign cordic_start = (state_reg == ST_GATE) && gate_pass;

    lsgd_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (angle_reg[ANG_CFG_W-1:0]),
        .res   (cres)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_ANGLE;
            ST_ANGLE:  if (cnt_reg == CNT_W'(IDX_W - 1)) state_next = ST_GATE;
            ST_GATE:   state_next = gate_pass ? ST_CORDIC : ST_DONE;
            ST_CORDIC: if (cres.done) state_next = ST_MULT;
            ST_MULT:   if (cnt_reg == CNT_W'(RANGE_W - 1)) state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_DPREP;
            ST_DPREP:  state_next = ST_DIST;
            ST_DIST:   if (cnt_reg == CNT_W'(MAG_W - 1)) state_next = ST_CMP;
            ST_CMP:    state_next = ST_DONE;
            ST_DONE:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        vx = (accx_reg + MUL_W'(16384)) >>> 15;
        vy = (accy_reg + MUL_W'(16384)) >>> 15;
        dx = DX_W'(cx_reg) - DX_W'(prev_x_reg);
        dy = DX_W'(cy_reg) - DX_W'(prev_y_reg);

        cnt_next       = cnt_reg + 1'b1;
        counter_next   = counter_reg;
        have_prev_next = have_prev_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        range_next     = range_reg;
        end_next       = end_reg;
        idx_next       = idx_reg;
        idx_sh_next    = idx_sh_reg >> 1;
        angle_next     = angle_reg;
        step_sh_next   = step_sh_reg <<< 1;
        rsh_next       = rsh_reg >> 1;
        mcx_next       = mcx_reg <<< 1;
        mcy_next       = mcy_reg <<< 1;
        accx_next      = accx_reg;
        accy_next      = accy_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        dxs_next       = dxs_reg >> 1;
        dys_next       = dys_reg >> 1;
        mdx_next       = mdx_reg << 1;
        mdy_next       = mdy_reg << 1;
        sq_next        = sq_reg;
        dds_next       = dds_reg >> 1;
        mdd_next       = mdd_reg << 1;
        dd_next        = dd_reg;
        keep_next      = keep_reg;
        px_next        = px_reg;
        py_next        = py_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next     = '0;
                range_next   = range;
                end_next     = scan_end;
                idx_next     = counter_reg;
                idx_sh_next  = counter_reg;
                angle_next   = ANG_W'(ang_start_reg);
                step_sh_next = ANG_W'(ang_step_reg);
            end
            ST_ANGLE:
            begin
                if (idx_sh_reg[0])
                begin
                    angle_next = angle_reg + step_sh_reg;
                end
            end
            ST_GATE:
            begin
                keep_next = 1'b0;
                px_next   = '0;
                py_next   = '0;
            end
            ST_CORDIC:
            begin
                cnt_next  = '0;
                rsh_next  = range_reg;
                mcx_next  = MUL_W'(cres.cos_v);
                mcy_next  = MUL_W'(cres.sin_v);
                accx_next = '0;
                accy_next = '0;
            end
            ST_MULT:
            begin
                if (rsh_reg[0])
                begin
                    accx_next = accx_reg + mcx_reg;
                    accy_next = accy_reg + mcy_reg;
                end
            end
            ST_ROUND:
            begin
                cx_next = (vx > PT_MAX) ? PT_W'(PT_MAX) :
                          (vx < PT_MIN) ? PT_W'(PT_MIN) : vx[PT_W-1:0];
                cy_next = (vy > PT_MAX) ? PT_W'(PT_MAX) :
                          (vy < PT_MIN) ? PT_W'(PT_MIN) : vy[PT_W-1:0];
            end
            ST_DPREP:
            begin
                cnt_next = '0;
                dxs_next = dx[DX_W-1] ? MAG_W'(-dx) : dx[MAG_W-1:0];
                dys_next = dy[DX_W-1] ? MAG_W'(-dy) : dy[MAG_W-1:0];
                mdx_next = SQ_W'(dx[DX_W-1] ? MAG_W'(-dx) : dx[MAG_W-1:0]);
                mdy_next = SQ_W'(dy[DX_W-1] ? MAG_W'(-dy) : dy[MAG_W-1:0]);
                dds_next = dec_dist_reg;
                mdd_next = DD_W'(dec_dist_reg);
                sq_next  = '0;
                dd_next  = '0;
            end
            ST_DIST:
            begin
                sq_next = sq_reg + (dxs_reg[0] ? mdx_reg : '0) + (dys_reg[0] ? mdy_reg : '0);
                if (dds_reg[0])
                begin
                    dd_next = dd_reg + mdd_reg;
                end
            end
            ST_CMP:
            begin
                keep_next = !have_prev_reg || (sq_reg >= SQ_W'(dd_reg));
                px_next   = (!have_prev_reg || (sq_reg >= SQ_W'(dd_reg))) ? cx_reg : '0;
                py_next   = (!have_prev_reg || (sq_reg >= SQ_W'(dd_reg))) ? cy_reg : '0;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    if (end_reg)
                    begin
                        counter_next   = '0;
                        have_prev_next = 1'b0;
                        prev_x_next    = '0;
                        prev_y_next    = '0;
                    end
                    else
                    begin
                        if (idx_reg < IDX_W'(IDX_LIMIT))
                        begin
                            counter_next = idx_reg + 1'b1;
                        end
                        if (keep_reg)
                        begin
                            have_prev_next = 1'b1;
                            prev_x_next    = px_reg;
                            prev_y_next    = py_reg;
                        end
                    end
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            counter_reg   <= '0;
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            out_valid_reg <= 1'b0;
            range_min_reg <= RANGE_W'(RST_RANGE_MIN);
            range_max_reg <= RANGE_W'(RST_RANGE_MAX);
            gate_min_reg  <= ANG_CFG_W'(RST_GATE_MIN);
            gate_max_reg  <= ANG_CFG_W'(RST_GATE_MAX);
            ang_start_reg <= ANG_CFG_W'(RST_ANG_START);
            ang_step_reg  <= STEP_W'(RST_ANG_STEP);
            dec_dist_reg  <= DEC_W'(RST_DEC_DIST);
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            counter_reg   <= counter_next;
            have_prev_reg <= have_prev_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_RANGE_MIN: range_min_reg <= cfg_data[RANGE_W-1:0];
                    CFG_RANGE_MAX: range_max_reg <= cfg_data[RANGE_W-1:0];
                    CFG_GATE_MIN:  gate_min_reg  <= cfg_data[ANG_CFG_W-1:0];
                    CFG_GATE_MAX:  gate_max_reg  <= cfg_data[ANG_CFG_W-1:0];
                    CFG_ANG_START: ang_start_reg <= cfg_data[ANG_CFG_W-1:0];
                    CFG_ANG_STEP:  ang_step_reg  <= cfg_data[STEP_W-1:0];
                    CFG_DEC_DIST:  dec_dist_reg  <= cfg_data[DEC_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        range_reg   <= range_next;
        end_reg     <= end_next;
        idx_reg     <= idx_next;
        idx_sh_reg  <= idx_sh_next;
        angle_reg   <= angle_next;
        step_sh_reg <= step_sh_next;
        rsh_reg     <= rsh_next;
        mcx_reg     <= mcx_next;
        mcy_reg     <= mcy_next;
        accx_reg    <= accx_next;
        accy_reg    <= accy_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        dxs_reg     <= dxs_next;
        dys_reg     <= dys_next;
        mdx_reg     <= mdx_next;
        mdy_reg     <= mdy_next;
        sq_reg      <= sq_next;
        dds_reg     <= dds_next;
        mdd_reg     <= mdd_next;
        dd_reg      <= dd_next;
        keep_reg    <= keep_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        if (out_load)
        begin
            keep_o_reg <= keep_reg;
            px_o_reg   <= px_reg;
            py_o_reg   <= py_reg;
            idx_o_reg  <= idx_reg;
            eos_o_reg  <= end_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign keep        = keep_o_reg;
    assign point_x     = px_o_reg;
    assign point_y     = py_o_reg;
    assign beam_index  = idx_o_reg;
    assign end_of_scan = eos_o_reg;

    `LSGD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `LSGD_ASSERT_IMPL(a_drop_zero, out_valid && !keep, point_x == '0 && point_y == '0)
    `LSGD_ASSERT_IMPL(a_cordic_done_state, cres.done, state_reg == ST_CORDIC)

endmodule
